@@ hdl/delimited_row_framer_assert.svh @@
// Assertion macros for the row framer.
`ifndef DELIMITED_ROW_FRAMER_ASSERT_SVH
`define DELIMITED_ROW_FRAMER_ASSERT_SVH

`ifndef SYNTH
`define DRF_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("row framer check failed");
`define DRF_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("row framer check failed");
`else
`define DRF_ASSERT_IMP(label, clk, rstn, ante, cons)
`define DRF_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif

`endif

@@ hdl/drf_pkg.sv @@
package drf_pkg;

    localparam int DRF_MAX_ROW_LEN = 4096;
    localparam int BATCH_W = 20;
    localparam int CFG_INDEX_W = 3;

    localparam logic [7:0] NL_CHAR = 8'd10;
    localparam logic [7:0] DELIM_RESET = 8'd124;
    localparam logic [BATCH_W-1:0] BATCH_RESET = BATCH_W'(10000);

    localparam logic [2:0] MODE_NORMAL   = 3'd0;
    localparam logic [2:0] MODE_ENCL     = 3'd1;
    localparam logic [2:0] MODE_ENCL_ESC = 3'd2;
    localparam logic [2:0] MODE_ESC      = 3'd3;
    localparam logic [2:0] MODE_TRAIL    = 3'd4;

    localparam logic [CFG_INDEX_W-1:0] REG_ENCL_EN  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ENCL_CH  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ESC_CH   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DELIM_CH = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_BATCH    = 3'd4;

    typedef struct packed {
        logic               enclosure_enable;
        logic [7:0]         enclose_char;
        logic [7:0]         escape_char;
        logic [7:0]         delimiter_char;
        logic [BATCH_W-1:0] batch_rows;
    } cfg_t;

    typedef struct packed {
        logic [2:0]         mode;
        logic [BATCH_W-1:0] batch_count;
        logic               error;
        logic               finished;
    } state_t;

    typedef struct packed {
        logic               has_byte;
        logic [7:0]         out_byte;
        logic               end_of_row;
        logic               end_of_batch;
        logic [BATCH_W-1:0] rows_in_batch;
        logic               row_too_long;
        logic               end_of_data;
    } result_t;

endpackage

@@ hdl/drf_cfg.sv @@
module drf_cfg
    import drf_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   wr_en,
    input  logic [CFG_INDEX_W-1:0] wr_index,
    input  logic [BATCH_W-1:0]     wr_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (wr_index)
                REG_ENCL_EN:  cfg_next.enclosure_enable = wr_data[0];
                REG_ENCL_CH:  cfg_next.enclose_char = wr_data[7:0];
                REG_ESC_CH:   cfg_next.escape_char = wr_data[7:0];
                REG_DELIM_CH: cfg_next.delimiter_char = wr_data[7:0];
                REG_BATCH:    cfg_next.batch_rows = wr_data;
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enclosure_enable <= 1'b0;
            cfg_reg.enclose_char <= 8'd0;
            cfg_reg.escape_char <= 8'd0;
            cfg_reg.delimiter_char <= DELIM_RESET;
            cfg_reg.batch_rows <= BATCH_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ hdl/drf_scan.sv @@
module drf_scan
    import drf_pkg::*;
#(
    parameter int MAX_ROW_LEN = DRF_MAX_ROW_LEN,
    parameter int ROW_LEN_W = $clog2(MAX_ROW_LEN)
) (
    input  cfg_t                 cfg,
    input  state_t               st,
    input  logic [ROW_LEN_W-1:0] row_len,
    input  logic                 kind,
    input  logic [7:0]           data_byte,
    output state_t               st_next,
    output logic [ROW_LEN_W-1:0] row_len_next,
    output result_t              res
);

    logic [BATCH_W-1:0] limit;
    logic [BATCH_W-1:0] count_inc;
    logic               batch_full;
    logic [2:0]         mode_eff;
    logic [2:0]         mode_new;
    logic               ends;

    assign limit = (cfg.batch_rows == '0) ? BATCH_W'(1) : cfg.batch_rows;
    assign count_inc = st.batch_count + BATCH_W'(1);
    assign batch_full = (count_inc >= limit);

    always_comb begin
        mode_eff = st.mode;
        if (st.mode == MODE_TRAIL && (data_byte == NL_CHAR || data_byte == cfg.delimiter_char)) begin
            mode_eff = MODE_NORMAL;
        end
        mode_new = MODE_NORMAL;
        ends = 1'b0;
        if (!cfg.enclosure_enable) begin
            ends = (data_byte == NL_CHAR);
        end else begin
            case (mode_eff)
                MODE_ENCL: begin
                    if (data_byte == cfg.enclose_char) begin
                        ends = (data_byte == NL_CHAR);
                        mode_new = ends ? MODE_NORMAL : MODE_TRAIL;
                    end else if (data_byte == cfg.escape_char) begin
                        mode_new = MODE_ENCL_ESC;
                    end else begin
                        mode_new = MODE_ENCL;
                    end
                end
                MODE_ENCL_ESC: mode_new = MODE_ENCL;
                MODE_ESC: begin
                    ends = (data_byte == NL_CHAR);
                end
                MODE_TRAIL: mode_new = MODE_TRAIL;
                default: begin
                    if (data_byte == cfg.enclose_char) begin
                        mode_new = MODE_ENCL;
                    end else if (data_byte == cfg.escape_char) begin
                        mode_new = MODE_ESC;
                    end else begin
                        ends = (data_byte == NL_CHAR);
                    end
                end
            endcase
        end
    end

    always_comb begin
        res = '0;
        res.row_too_long = st.error;
        st_next = st;
        row_len_next = row_len;
        if (st.finished) begin
            st_next = st;
        end else if (kind) begin
            st_next.finished = 1'b1;
            res.end_of_data = 1'b1;
            if (!st.error) begin
                res.rows_in_batch = st.batch_count;
                if (row_len != '0 || st.mode != MODE_NORMAL) begin
                    res.has_byte = 1'b1;
                    res.out_byte = NL_CHAR;
                    res.end_of_row = 1'b1;
                    res.rows_in_batch = count_inc;
                end
                res.end_of_batch = 1'b1;
                st_next.batch_count = '0;
                st_next.mode = MODE_NORMAL;
                row_len_next = '0;
            end
        end else if (!st.error) begin
            if (!ends && row_len >= ROW_LEN_W'(MAX_ROW_LEN - 1)) begin
                st_next.error = 1'b1;
                res.row_too_long = 1'b1;
            end else begin
                res.has_byte = 1'b1;
                res.out_byte = data_byte;
                st_next.mode = mode_new;
                if (ends) begin
                    res.end_of_row = 1'b1;
                    res.rows_in_batch = count_inc;
                    row_len_next = '0;
                    if (batch_full) begin
                        res.end_of_batch = 1'b1;
                        st_next.batch_count = '0;
                    end else begin
                        st_next.batch_count = count_inc;
                    end
                end else begin
                    res.rows_in_batch = st.batch_count;
                    row_len_next = row_len + ROW_LEN_W'(1);
                end
            end
        end
    end

endmodule

@@ hdl/delimited_row_framer.sv @@
// Delimited row framer: splits a byte stream into rows, one result item per input item,
// at one item per clock unless m_tready stalls it, via an input register, then a result
// register. The rate is set by the per-byte scan state, updated in the same cycle as the
// result is formed, so each byte sees the state left by the one before. Rows hold at most
// MAX_ROW_LEN bytes including their newline; an overlong row sets a sticky error that
// drops output bytes until reset, and after the end-of-stream item every further item
// answers empty until reset. Configuration must be taken only while idle (not enforced).
`include "delimited_row_framer_assert.svh"

module delimited_row_framer
    import drf_pkg::*;
#(
    parameter int MAX_ROW_LEN = DRF_MAX_ROW_LEN
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] data_byte
    input  logic                   s_tuser,   // [0] kind
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [31:0]            m_tdata,   // [7:0] out_byte, [27:8] rows_in_batch
    output logic [3:0]             m_tuser,   // [0] has_byte, [1] end_of_batch,
                                              // [2] row_too_long, [3] end_of_data
    output logic                   m_tlast,   // end_of_row
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [BATCH_W-1:0]     cfg_data
);

    localparam int ROW_LEN_W = $clog2(MAX_ROW_LEN);

    cfg_t                 cfg;
    logic                 in_valid_reg;
    logic                 in_kind_reg;
    logic [7:0]           in_byte_reg;
    logic                 out_valid_reg;
    result_t              res_reg;
    result_t              res_next;
    state_t               state_reg;
    state_t               state_next;
    logic [ROW_LEN_W-1:0] row_len_reg;
    logic [ROW_LEN_W-1:0] row_len_next;
    logic                 advance;
    logic                 in_take;

    assign cfg_ready = 1'b1;

    drf_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    drf_scan #(
        .MAX_ROW_LEN (MAX_ROW_LEN),
        .ROW_LEN_W   (ROW_LEN_W)
    ) u_scan (
        .cfg          (cfg),
        .st           (state_reg),
        .row_len      (row_len_reg),
        .kind         (in_kind_reg),
        .data_byte    (in_byte_reg),
        .st_next      (state_next),
        .row_len_next (row_len_next),
        .res          (res_next)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{mode: MODE_NORMAL, batch_count: '0, error: 1'b0,
                               finished: 1'b0};
            row_len_reg   <= '0;
        end else begin
            if (in_take) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
                row_len_reg   <= row_len_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_kind_reg <= s_tuser;
            in_byte_reg <= s_tdata;
        end
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, res_reg.rows_in_batch, res_reg.out_byte};
    assign m_tuser  = {res_reg.end_of_data, res_reg.row_too_long, res_reg.end_of_batch,
                       res_reg.has_byte};
    assign m_tlast  = res_reg.end_of_row;

    `DRF_ASSERT_NXT(a_error_sticky, aclk, aresetn, state_reg.error, state_reg.error)
    `DRF_ASSERT_NXT(a_finished_sticky, aclk, aresetn, state_reg.finished, state_reg.finished)
    `DRF_ASSERT_IMP(a_no_byte_on_error, aclk, aresetn, m_tvalid && m_tuser[0], !m_tuser[2])
    `DRF_ASSERT_IMP(a_row_ends_in_nl, aclk, aresetn, m_tvalid && m_tlast, m_tdata[7:0] == NL_CHAR)

endmodule
